// ===== src/fvpc_pkg.sv =====
// shared types, codes and constants of the floating valve position control
package fvpc_pkg;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_SET     = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [1:0] DRV_STOP  = 2'd0;
  localparam logic [1:0] DRV_OPEN  = 2'd1;
  localparam logic [1:0] DRV_CLOSE = 2'd2;

  localparam logic [1:0] REG_OPEN_TIME = 2'd0;
  localparam logic [1:0] REG_DEADBAND  = 2'd1;
  localparam logic [1:0] REG_MARGIN    = 2'd2;

  localparam logic [9:0]  FULL_POWER  = 10'd1000;
  localparam logic [17:0] STEP_MS     = 18'd10;
  localparam logic [17:0] POS_MAX     = 18'h3ffff;
  localparam logic [17:0] MS_PER_S    = 18'd1000;
  localparam logic [15:0] TICKS_PER_S = 16'd100;

  localparam logic [7:0] OPEN_TIME_RST = 8'd10;
  localparam logic [7:0] DEADBAND_RST  = 8'd0;
  localparam logic [7:0] MARGIN_RST    = 8'd5;

  typedef struct packed {
    logic [7:0] open_time_s;
    logic [7:0] deadband_s;
    logic [7:0] safety_margin_s;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  drive;
    logic        open_pin;
    logic        close_pin;
    logic [17:0] position_ms;
    logic        power_rejected;
  } res_t;

endpackage

// ===== src/fvpc_in_if.sv =====
// input channel: command transaction with kind and requested power
interface fvpc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [9:0] power_value;

  modport source (output valid, output kind, output power_value, input ready);
  modport sink (input valid, input kind, input power_value, output ready);
endinterface

// ===== src/fvpc_out_if.sv =====
// result channel: drive state, pin levels, position estimate and reject flag
interface fvpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  drive;
  logic        open_pin;
  logic        close_pin;
  logic [17:0] position_ms;
  logic        power_rejected;

  modport source (output valid, output drive, output open_pin, output close_pin,
                  output position_ms, output power_rejected, input ready);
  modport sink (input valid, input drive, input open_pin, input close_pin,
                input position_ms, input power_rejected, output ready);
endinterface

// ===== src/fvpc_regs.sv =====
// apb register file holding open time, deadband and safety margin
module fvpc_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output fvpc_pkg::cfg_t     cfg
);

  logic [7:0] open_time_r, open_time_nxt;
  logic [7:0] deadband_r, deadband_nxt;
  logic [7:0] margin_r, margin_nxt;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    open_time_nxt = open_time_r;
    deadband_nxt  = deadband_r;
    margin_nxt    = margin_r;
    if (wr_en) begin
      case (idx)
        fvpc_pkg::REG_OPEN_TIME: open_time_nxt = pwdata[7:0];
        fvpc_pkg::REG_DEADBAND:  deadband_nxt  = pwdata[7:0];
        fvpc_pkg::REG_MARGIN:    margin_nxt    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_time_r <= fvpc_pkg::OPEN_TIME_RST;
      deadband_r  <= fvpc_pkg::DEADBAND_RST;
      margin_r    <= fvpc_pkg::MARGIN_RST;
    end else begin
      open_time_r <= open_time_nxt;
      deadband_r  <= deadband_nxt;
      margin_r    <= margin_nxt;
    end
  end

  always_comb begin
    case (idx)
      fvpc_pkg::REG_OPEN_TIME: prdata = {24'd0, open_time_r};
      fvpc_pkg::REG_DEADBAND:  prdata = {24'd0, deadband_r};
      fvpc_pkg::REG_MARGIN:    prdata = {24'd0, margin_r};
      default:                 prdata = 32'd0;
    endcase
  end

  assign cfg.open_time_s     = open_time_r;
  assign cfg.deadband_s      = deadband_r;
  assign cfg.safety_margin_s = margin_r;

endmodule

// ===== src/fvpc_core.sv =====
// valve state and single pass tick, set power and restart update
module fvpc_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [1:0]      kind,
  input  logic [9:0]      power_value,
  input  fvpc_pkg::cfg_t  cfg,
  output fvpc_pkg::res_t  res
);

  logic [15:0] ict_r, ict_nxt;
  logic [17:0] pos_r, pos_nxt;
  logic [9:0]  tp_r, tp_nxt;
  logic [1:0]  drv_r, drv_nxt;
  logic        rej;

  logic [17:0] target;
  logic [17:0] band;
  logic [17:0] diff;
  logic [18:0] pos_up;
  logic [8:0]  secs;
  logic [15:0] ict_load;

  assign target   = {8'd0, tp_r} * {10'd0, cfg.open_time_s};
  assign band     = {10'd0, cfg.deadband_s} * fvpc_pkg::MS_PER_S;
  assign diff     = (target > pos_r) ? target - pos_r : pos_r - target;
  assign pos_up   = {1'b0, pos_r} + {1'b0, fvpc_pkg::STEP_MS};
  assign secs     = {1'b0, cfg.open_time_s} + {1'b0, cfg.safety_margin_s};
  assign ict_load = {7'd0, secs} * fvpc_pkg::TICKS_PER_S;

  always_comb begin
    ict_nxt = ict_r;
    pos_nxt = pos_r;
    tp_nxt  = tp_r;
    drv_nxt = drv_r;
    rej     = 1'b0;
    case (kind)
      fvpc_pkg::KIND_TICK: begin
        if (ict_r != 16'd0) begin
          ict_nxt = ict_r - 16'd1;
          drv_nxt = fvpc_pkg::DRV_CLOSE;
        end else if (tp_r == fvpc_pkg::FULL_POWER) begin
          drv_nxt = fvpc_pkg::DRV_OPEN;
        end else if (tp_r == 10'd0) begin
          drv_nxt = fvpc_pkg::DRV_STOP;
        end else if (band != 18'd0 && diff < band) begin
          drv_nxt = fvpc_pkg::DRV_STOP;
        end else if (target > pos_r) begin
          drv_nxt = fvpc_pkg::DRV_OPEN;
          pos_nxt = pos_up[18] ? fvpc_pkg::POS_MAX : pos_up[17:0];
        end else if (target < pos_r) begin
          drv_nxt = fvpc_pkg::DRV_CLOSE;
          pos_nxt = (pos_r >= fvpc_pkg::STEP_MS) ? pos_r - fvpc_pkg::STEP_MS : 18'd0;
        end else begin
          drv_nxt = fvpc_pkg::DRV_STOP;
        end
      end
      fvpc_pkg::KIND_SET: begin
        if (power_value > fvpc_pkg::FULL_POWER) begin
          rej = 1'b1;
        end else begin
          tp_nxt = power_value;
        end
      end
      fvpc_pkg::KIND_RESTART: begin
        ict_nxt = ict_load;
        pos_nxt = 18'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ict_r <= 16'd0;
      pos_r <= 18'd0;
      tp_r  <= 10'd0;
      drv_r <= fvpc_pkg::DRV_STOP;
    end else if (fire) begin
      ict_r <= ict_nxt;
      pos_r <= pos_nxt;
      tp_r  <= tp_nxt;
      drv_r <= drv_nxt;
    end
  end

  assign res.drive          = drv_nxt;
  assign res.open_pin       = (drv_nxt == fvpc_pkg::DRV_OPEN);
  assign res.close_pin      = (drv_nxt == fvpc_pkg::DRV_CLOSE);
  assign res.position_ms    = pos_nxt;
  assign res.power_rejected = rej;

`ifndef SYNTHESIS
  a_init_close: assert property (@(posedge clk) disable iff (!rst_n)
    fire && kind == fvpc_pkg::KIND_TICK && ict_r != 16'd0
    |=> drv_r == fvpc_pkg::DRV_CLOSE && pos_r == $past(pos_r))
    else $error("initial close tick did not close with position held");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && kind == fvpc_pkg::KIND_RESTART |=> pos_r == 18'd0 && tp_r == $past(tp_r))
    else $error("restart did not clear position or lost target power");
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    fire && kind == fvpc_pkg::KIND_SET && power_value > fvpc_pkg::FULL_POWER
    |=> tp_r == $past(tp_r))
    else $error("rejected power request changed the target");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pos_r) && $stable(drv_r) && $stable(ict_r) && $stable(tp_r))
    else $error("valve state moved without a transaction");
`endif

endmodule

// ===== src/floating_valve_position_control.sv =====
// Three-point floating valve controller with an estimated travel position.
// One transaction is taken every clock cycle unless a stalled result holds it back.
// Its result passes from the input register, which holds the command, to the
// result register; the whole tick update (target product, deadband compare,
// step of ten ms) is done in the single stage between the two registers.
// While a result waits on a stalled result channel, the input register holds its
// transaction, so at most two transactions are in flight.
// Configuration writes are taken at any time through the apb port and
// should be made while no transaction is in flight.
module floating_valve_position_control (
  input  logic        clk,
  input  logic        rst_n,
  fvpc_in_if.sink     in_ch,
  fvpc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fvpc_pkg::cfg_t cfg;
  fvpc_pkg::res_t res;

  logic       s1_v_r, s1_v_nxt;
  logic [1:0] s1_kind_r;
  logic [9:0] s1_power_r;
  logic       out_v_r, out_v_nxt;
  fvpc_pkg::res_t out_r;
  logic       adv;
  logic       fire;
  logic       in_acc;

  fvpc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fvpc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .kind        (s1_kind_r),
    .power_value (s1_power_r),
    .cfg         (cfg),
    .res         (res)
  );

  assign adv         = !out_v_r || out_ch.ready;
  assign fire        = s1_v_r && adv;
  assign in_ch.ready = !s1_v_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign s1_v_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : s1_v_r);
  assign out_v_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= in_ch.kind;
      s1_power_r <= in_ch.power_value;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.drive          = out_r.drive;
  assign out_ch.open_pin       = out_r.open_pin;
  assign out_ch.close_pin      = out_r.close_pin;
  assign out_ch.position_ms    = out_r.position_ms;
  assign out_ch.power_rejected = out_r.power_rejected;

`ifndef SYNTHESIS
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_r))
    else $error("stalled result was lost or changed");
  a_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_r.open_pin && out_r.close_pin))
    else $error("open and close lines driven together");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted transaction not held in the input register");
`endif

endmodule
